// ===== rtl/dht_pkg.sv =====
// dht_pkg: shared types and constants of the double hashed table unit
// no dependencies

package dht_pkg;

  localparam int unsigned SIZE_BITS  = 11;
  localparam int unsigned SLOT_BITS  = 10;
  localparam int unsigned COUNT_BITS = 11;
  localparam int unsigned WORD_OUT_BITS = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // request to the divider: numerator and divisor
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;

  // reply from the divider
  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/dht_div.sv =====
// dht_div: restoring divider, one quotient bit per cycle
// depends on dht_pkg

module dht_div (
  input  logic              clk,
  input  logic              rst,
  input  dht_pkg::div_req_t req,
  output dht_pkg::div_rsp_t rsp
);
  import dht_pkg::*;

  logic [31:0] quo;
  logic [16:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [15:0] den;
  logic [16:0] trial;
  logic [16:0] diff;

  // shift in next numerator bit and try a subtract
  always_comb begin
    trial = {rem[15:0], quo[31]};
    diff  = trial - {1'b0, den};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (!diff[16]) begin
          rem <= diff;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[15:0];

endmodule

// ===== rtl/double_hash_table_insert_lookup_unit.sv =====
// Double hashed open addressed table, insert and lookup by key. An operation
// runs two passes of a one bit per cycle divider (key by size, then quotient
// by size), then 1 to PROBE_LIMIT probes, fewer when the walk returns to the
// home slot, each a read and a check through the slot memory read port. It
// then holds the result beat until m_axis_tready and returns to idle, where
// the next beat is taken.
// After reset a clearing pass over all CAPACITY slots empties the valid memory
// before the first beat is taken.
// Depends on dht_pkg and dht_div.

module double_hash_table_insert_lookup_unit #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned PROBE_LIMIT = 10,
  parameter int unsigned KEY_BITS    = 18,
  parameter int unsigned ENTRY_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_value
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // slot_index, stored_entry, occupied_count, pad
  output logic        m_axis_tuser    // success
);
  import dht_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_DIV2  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [SIZE_BITS-1:0] table_size;
  logic [AW:0] size;
  logic [ENTRY_BITS-1:0] word;
  logic        op;
  logic [31:0] key;
  logic [31:0] in_key;
  logic [AW-1:0] home;
  logic [AW-1:0] step;
  logic [AW-1:0] j;
  logic [PW-1:0] probe;
  logic [COUNT_BITS-1:0] used_count;
  logic [AW-1:0] clr;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [ENTRY_BITS-1:0] mem_word [CAPACITY];
  logic                  mem_valid [CAPACITY];
  logic [ENTRY_BITS-1:0] rd_word;
  logic                  rd_valid;
  logic                  we_word;
  logic                  we_valid;
  logic [AW-1:0]         waddr;
  logic                  wvalid;

  logic [AW:0]   nxt;
  logic          hit;
  logic          last_probe;

  // effective size, clamped to 1..CAPACITY
  always_comb begin
    if (table_size == '0) size = (AW+1)'(1);
    else if (32'(table_size) > CAPACITY) size = (AW+1)'(CAPACITY);
    else size = (AW+1)'(table_size);
  end

  // key of the incoming beat
  always_comb begin
    in_key = s_axis_tdata & 32'((64'd1 << KEY_BITS) - 1);
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) table_size <= 11'd31;
    else if (cfg_we) table_size <= cfg_wdata;
  end

  dht_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // slot memories, one read port each
  always_ff @(posedge clk) begin
    if (we_word) mem_word[waddr] <= word;
    if (we_valid) mem_valid[waddr] <= wvalid;
    rd_word  <= mem_word[j];
    rd_valid <= mem_valid[j];
  end

  // probe evaluation
  always_comb begin
    if (op == OP_INSERT) hit = !rd_valid;
    else hit = rd_valid && ((rd_word ^ ENTRY_BITS'(key)) & ENTRY_BITS'((64'd1 << KEY_BITS) - 1))
               == '0;
    nxt = (AW+1)'({1'b0, j} + {1'b0, step});
    if (nxt >= size) nxt = nxt - size;
    last_probe = (32'(probe) + 1 >= PROBE_LIMIT) || (nxt[AW-1:0] == home);
    we_word  = (state == S_CHECK) && (op == OP_INSERT) && hit;
    we_valid = we_word || (state == S_CLEAR);
    waddr    = (state == S_CLEAR) ? clr : j;
    wvalid   = (state != S_CLEAR);
    dreq.start = 1'b0;
    dreq.num   = key;
    dreq.den   = 16'(size);
    if (state == S_IDLE && s_axis_tvalid) begin
      dreq.start = 1'b1;
      dreq.num   = in_key;
    end
    if (state == S_DIV1 && drsp.done) begin
      dreq.start = 1'b1;
      dreq.num   = drsp.quo;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      used_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (32'(clr) == CAPACITY - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= s_axis_tuser;
            word  <= ENTRY_BITS'(s_axis_tdata);
            key   <= in_key;
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (drsp.done) begin
            home  <= AW'(drsp.rem);
            j     <= AW'(drsp.rem);
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (drsp.done) begin
            step  <= (drsp.rem == '0) ? AW'(1) : AW'(drsp.rem);
            probe <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (hit) begin
            m_axis_tuser <= 1'b1;
            m_axis_tdata[SLOT_BITS-1:0] <= SLOT_BITS'(j);
            m_axis_tdata[41:10] <= (op == OP_INSERT) ? WORD_OUT_BITS'(word)
                                                     : WORD_OUT_BITS'(rd_word);
            if (op == OP_INSERT && used_count != '1) begin
              used_count <= used_count + 1'b1;
              m_axis_tdata[52:42] <= used_count + 1'b1;
            end else m_axis_tdata[52:42] <= used_count;
            state <= S_OUT;
          end else if (last_probe) begin
            m_axis_tuser <= 1'b0;
            m_axis_tdata[41:0]  <= '0;
            m_axis_tdata[52:42] <= used_count;
            state <= S_OUT;
          end else begin
            j     <= nxt[AW-1:0];
            probe <= probe + PW'(1);
            state <= S_READ;
          end
          m_axis_tdata[55:53] <= '0;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/double_hash_table_insert_lookup_unit_test.sv =====
// testbench of the double hashed table unit: directed and random insert and lookup
// beats checked against a behavioural table model; depends on dht_pkg and the rtl

module double_hash_table_insert_lookup_unit_test;
  import dht_pkg::*;

  localparam int unsigned CAP      = 1024;
  localparam int unsigned PROBES   = 10;
  localparam int unsigned KEYW     = 18;
  localparam logic [31:0] KEY_MASK = (32'd1 << KEYW) - 1;

  typedef struct {
    logic        op;
    logic [31:0] word;
  } table_op_t;

  typedef struct {
    logic        success;
    logic [9:0]  slot;
    logic [31:0] stored;
    logic [10:0] count;
  } table_reply_t;

  logic        clk, rst;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        s_axis_tready_q;

  double_hash_table_insert_lookup_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // shadow of the table
  logic [10:0] size_reg;
  logic [31:0] shadow_words [CAP];
  bit          shadow_valid [CAP];
  logic [10:0] shadow_count;

  table_op_t    pending_ops [$];
  table_reply_t expected_replies [$];
  int  errors = 0;
  int  accepted = 0, replies_seen = 0, hits = 0, full_fails = 0;
  bit  no_idle = 0;
  bit  hold_sender = 0;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // probe sequence as the block walks it
  function automatic table_reply_t table_apply(table_op_t t);
    table_reply_t r;
    int unsigned sz, key, home, stride, j;
    sz = size_reg;
    if (sz == 0) sz = 1;
    if (sz > CAP) sz = CAP;
    key = t.word & KEY_MASK;
    home = key % sz;
    stride = (key / sz) % sz;
    if (stride == 0) stride = 1;
    j = home;
    r.success = 1'b0; r.slot = '0; r.stored = '0;
    for (int i = 0; i < PROBES && (i == 0 || j != home); i++) begin
      if (t.op == OP_INSERT) begin
        if (!shadow_valid[j]) begin
          shadow_words[j] = t.word;
          shadow_valid[j] = 1;
          if (shadow_count != 11'h7ff) shadow_count++;
          r.success = 1'b1;
        end
      end else if (shadow_valid[j] && (shadow_words[j] & KEY_MASK) == key) begin
        r.success = 1'b1;
      end
      if (r.success) begin
        r.slot = j[9:0];
        r.stored = shadow_words[j];
        break;
      end
      j = (j + stride) % sz;
    end
    r.count = shadow_count;
    return r;
  endfunction

  // driver: sender side, when held it waits until every reply is back
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready_q) begin
      if (pending_ops.size() > 0 && (!hold_sender || expected_replies.size() == 0) &&
          (no_idle || $urandom_range(99) >= 10)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_ops[0].op;
        s_axis_tdata  <= pending_ops[0].word;
        void'(pending_ops.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // remember whether the last beat went at the rising edge
  always @(posedge clk) s_axis_tready_q <= !rst && s_axis_tvalid && s_axis_tready;

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 10);
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    table_op_t    t;
    table_reply_t e, got;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      t.op = s_axis_tuser;
      t.word = s_axis_tdata;
      expected_replies.push_back(table_apply(t));
      accepted++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.success = m_axis_tuser;
      got.slot    = m_axis_tdata[9:0];
      got.stored  = m_axis_tdata[41:10];
      got.count   = m_axis_tdata[52:42];
      replies_seen++;
      if (got.success) hits++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected beat success=%0b slot=%0d entry=%h count=%0d",
                 $time, got.success, got.slot, got.stored, got.count);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (got.success !== e.success) begin
          $display("%0t: success expected %0b actual %0b", $time, e.success, got.success);
          errors++;
        end
        if (got.slot !== e.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, e.slot, got.slot);
          errors++;
        end
        if (got.stored !== e.stored) begin
          $display("%0t: entry expected %h actual %h", $time, e.stored, got.stored);
          errors++;
        end
        if (got.count !== e.count) begin
          $display("%0t: count expected %0d actual %0d", $time, e.count, got.count);
          errors++;
        end
      end
    end
  end

  task automatic queue_op(logic op, logic [31:0] word);
    table_op_t t;
    t.op = op;
    t.word = word;
    pending_ops.push_back(t);
  endtask

  // wait for the table to drain, then let the block settle
  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_size(logic [10:0] sz);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sz;
    size_reg = sz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // a phase of random traffic: new keys, mostly inserted, mixed with lookups of known keys
  task automatic random_phase(int n, int unsigned key_span);
    logic [31:0] keys [$];
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      if (keys.size() > 0 && $urandom_range(1)) begin
        w = keys[$urandom_range(keys.size() - 1)];
        if ($urandom_range(3) == 0) w = w ^ (32'd1 << $urandom_range(17));
        w[31:KEYW] = (32-KEYW)'($urandom);
        queue_op(OP_LOOKUP, w);
      end else begin
        w = $urandom;
        if ($urandom_range(3) != 0) w[KEYW-1:0] = KEYW'($urandom_range(key_span));
        keys.push_back(w);
        queue_op($urandom_range(9) == 0 ? OP_LOOKUP : OP_INSERT, w);
      end
    end
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_wdata = '0;
    size_reg = 11'd31;
    shadow_count = '0;
    foreach (shadow_valid[i]) shadow_valid[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, duplicates, misses, keys that share a home slot
    queue_op(OP_LOOKUP, 32'h0000_0000);
    queue_op(OP_INSERT, 32'h0000_0000);
    queue_op(OP_INSERT, 32'hffff_ffff);
    queue_op(OP_INSERT, 32'hffff_ffff);
    queue_op(OP_LOOKUP, 32'h0003_ffff);
    queue_op(OP_LOOKUP, 32'h5554_0000);
    queue_op(OP_INSERT, 32'h0000_001f);
    queue_op(OP_INSERT, 32'h0000_03e0);
    queue_op(OP_LOOKUP, 32'haaaa_aaaa);
    queue_op(OP_LOOKUP, 32'h0000_03e0);
    drain();

    // size zero acts as one slot: second insert fails
    set_size(11'd0);
    queue_op(OP_INSERT, 32'h1234_5678);
    queue_op(OP_INSERT, 32'h8765_4321);
    queue_op(OP_LOOKUP, 32'h0000_5678);
    drain();

    // sender holds off until everything is back, size above capacity
    set_size(11'h7ff);
    hold_sender = 1;
    random_phase(400, 2047);
    drain();
    hold_sender = 0;
    random_phase(400, 4095);
    drain();

    // small table filled past the point of failure, with no idling
    set_size(11'd7);
    no_idle = 1;
    random_phase(150, 200);
    drain();
    no_idle = 0;

    set_size(11'd1024);
    random_phase(150, 262143);
    drain();
    set_size(11'd1);
    random_phase(80, 50);
    drain();
    set_size(11'd513);
    random_phase(100, 262143);
    drain();

    $display("ran %0d operations, %0d replies, %0d successful, slots in use %0d",
             accepted, replies_seen, hits, shadow_count);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // timeout
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dht_pkg.sv
rtl/dht_div.sv
rtl/double_hash_table_insert_lookup_unit.sv
sim/double_hash_table_insert_lookup_unit_test.sv
